/* hdl/tnlf_pkg.sv */
package tnlf_pkg;

  // Defaults for the top-level parameters.
  localparam int NeedleBytesDef = 16;
  localparam int OffsetBitsDef  = 48;

  // Depth of the queue between the front and the back part.
  localparam int QueueDepth = 4;

  // Configuration port.
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 64;
  localparam int LenW     = 5;
  localparam int PatW     = 64;

  localparam logic [CfgIdxW-1:0] CFG_SCAN_ALL      = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_BASE_OFFSET   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_LEN     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_LEN    = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_PAT_LO  = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_FIRST_PAT_HI  = 3'd5;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_PAT_LO = 3'd6;
  localparam logic [CfgIdxW-1:0] CFG_SECOND_PAT_HI = 3'd7;

  // Record kinds carried on the output tuser.
  localparam logic KIND_LINE    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Needle settings seen by the front part.
  typedef struct packed {
    logic              scan_all;
    logic [LenW-1:0]   first_len;
    logic [LenW-1:0]   second_len;
    logic [2*PatW-1:0] first_pat;
    logic [2*PatW-1:0] second_pat;
  } needle_cfg_t;

  // Handshake between the record queue and the back part.
  typedef struct packed {
    logic not_empty;
    logic pop;
  } queue_ctrl_t;

endpackage

/* hdl/tnlf_front.sv */
module tnlf_front #(
  parameter int NeedleBytes = tnlf_pkg::NeedleBytesDef,
  parameter int OffsetBits  = tnlf_pkg::OffsetBitsDef,
  localparam int EntryW     = 4 * OffsetBits + 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  tnlf_pkg::needle_cfg_t cfg_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // byte_value
  input  logic                  s_axis_tlast,
  input  logic                  full_i,
  output logic                  push_o,
  output logic [EntryW-1:0]     entry_o
);
  import tnlf_pkg::*;

  localparam int HistDepth = (NeedleBytes > 1) ? NeedleBytes - 1 : 1;
  localparam int FillW     = (NeedleBytes > 1) ? $clog2(NeedleBytes) : 1;
  localparam int NumPatB   = (2 * PatW) / 8;

  localparam logic [7:0] NEWLINE   = 8'h0A;
  localparam logic [7:0] U_ASCII   = 8'h80;
  localparam logic [7:0] U_TWO_LO  = 8'hC2;
  localparam logic [7:0] U_TWO_HI  = 8'hDF;
  localparam logic [7:0] U_THR_LO  = 8'hE0;
  localparam logic [7:0] U_THR_HI  = 8'hEF;
  localparam logic [7:0] U_THR_SUR = 8'hED;
  localparam logic [7:0] U_FOUR_LO = 8'hF0;
  localparam logic [7:0] U_FOUR_HI = 8'hF4;
  localparam logic [7:0] U_LIM_A0  = 8'hA0;
  localparam logic [7:0] U_LIM_90  = 8'h90;
  localparam logic [7:0] U_CONT_M  = 8'hC0;
  localparam logic [7:0] U_CONT_V  = 8'h80;

  typedef enum logic [2:0] {
    RULE_NONE,
    RULE_GE_A0,
    RULE_LT_A0,
    RULE_GE_90,
    RULE_LT_90
  } rule_e;

  function automatic logic [7:0] needle_byte(logic [2*PatW-1:0] pat, int k);
    logic [7:0] b;
    b = 8'h00;
    if (k < NumPatB) begin
      b = pat[8*k +: 8];
    end
    return b;
  endfunction

  logic [OffsetBits-1:0] bytes_seen_q, bytes_seen_d;
  logic [OffsetBits-1:0] line_begin_q, line_begin_d;
  logic [OffsetBits-1:0] after_nl_q, after_nl_d;
  logic                  line_hit_q, line_hit_d;
  logic [FillW-1:0]      fill_q, fill_d;
  logic [1:0]            pend_q, pend_d;
  rule_e                 rule_q, rule_d;
  logic                  bad_q, bad_d;
  logic [7:0]            hist_q [HistDepth];

  logic                  accept;
  logic                  is_nl;
  logic [OffsetBits-1:0] cnt_inc;
  logic                  hit_first, hit_second;
  logic                  rec_line, rec_sum, sum_bad;
  logic [OffsetBits-1:0] line_stop, sum_after;
  logic [7:0]            c;

  assign c             = s_axis_tdata;
  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign is_nl         = (c == NEWLINE);
  assign cnt_inc       = (bytes_seen_q == '1) ? bytes_seen_q : bytes_seen_q + 1'b1;

  // Every possible needle length is checked against the history in parallel;
  // the configured length then picks its result.
  function automatic logic needle_hit(logic [LenW-1:0] len, logic [2*PatW-1:0] pat,
                                      logic [7:0] cb, logic [FillW-1:0] fill,
                                      logic [7:0] hist [HistDepth]);
    logic hit;
    logic eq;
    hit = 1'b0;
    for (int l = 1; l <= NeedleBytes; l++) begin
      eq = (needle_byte(pat, l - 1) == cb);
      for (int k = 0; k + 1 < l; k++) begin
        if (needle_byte(pat, k) != hist[l-2-k]) begin
          eq = 1'b0;
        end
      end
      if ((int'(len) == l) && (int'(fill) + 1 >= l) && eq) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  assign hit_first  = needle_hit(cfg_i.first_len, cfg_i.first_pat, c, fill_q, hist_q);
  assign hit_second = needle_hit(cfg_i.second_len, cfg_i.second_pat, c, fill_q, hist_q);

  always_comb begin
    bytes_seen_d = bytes_seen_q;
    line_begin_d = line_begin_q;
    after_nl_d   = after_nl_q;
    line_hit_d   = line_hit_q;
    fill_d       = fill_q;
    pend_d       = pend_q;
    rule_d       = rule_q;
    bad_d        = bad_q;
    rec_line     = 1'b0;
    rec_sum      = 1'b0;
    sum_bad      = 1'b0;
    line_stop    = cnt_inc;
    sum_after    = after_nl_q;

    if (accept) begin
      bytes_seen_d = cnt_inc;
      if (is_nl) begin
        rec_line     = cfg_i.scan_all || line_hit_q;
        line_stop    = bytes_seen_q;
        line_begin_d = cnt_inc;
        after_nl_d   = cnt_inc;
        line_hit_d   = 1'b0;
        fill_d       = '0;
        pend_d       = 2'd0;
        rule_d       = RULE_NONE;
        bad_d        = 1'b0;
      end else begin
        line_hit_d = line_hit_q || hit_first || hit_second;
        if (int'(fill_q) < NeedleBytes - 1) begin
          fill_d = fill_q + 1'b1;
        end
        // UTF-8 check of the current line's bytes.
        if (!bad_q) begin
          if (pend_q != 2'd0) begin
            if ((c & U_CONT_M) != U_CONT_V) begin
              bad_d = 1'b1;
            end else if ((rule_q == RULE_GE_A0 && c < U_LIM_A0) ||
                         (rule_q == RULE_LT_A0 && c >= U_LIM_A0) ||
                         (rule_q == RULE_GE_90 && c < U_LIM_90) ||
                         (rule_q == RULE_LT_90 && c >= U_LIM_90)) begin
              bad_d = 1'b1;
            end else begin
              rule_d = RULE_NONE;
              pend_d = pend_q - 2'd1;
            end
          end else if (c >= U_ASCII) begin
            if (c inside {[U_TWO_LO:U_TWO_HI]}) begin
              pend_d = 2'd1;
            end else if (c inside {[U_THR_LO:U_THR_HI]}) begin
              pend_d = 2'd2;
              rule_d = (c == U_THR_LO) ? RULE_GE_A0 :
                       (c == U_THR_SUR) ? RULE_LT_A0 : RULE_NONE;
            end else if (c inside {[U_FOUR_LO:U_FOUR_HI]}) begin
              pend_d = 2'd3;
              rule_d = (c == U_FOUR_LO) ? RULE_GE_90 :
                       (c == U_FOUR_HI) ? RULE_LT_90 : RULE_NONE;
            end else begin
              bad_d = 1'b1;
            end
          end
        end
        rec_line = s_axis_tlast && (cfg_i.scan_all || line_hit_d);
      end

      if (s_axis_tlast) begin
        rec_sum      = 1'b1;
        sum_after    = after_nl_d;
        sum_bad      = bad_d || (pend_d != 2'd0);
        // The stream ends: the next byte starts a fresh one.
        bytes_seen_d = '0;
        line_begin_d = '0;
        after_nl_d   = '0;
        line_hit_d   = 1'b0;
        fill_d       = '0;
        pend_d       = 2'd0;
        rule_d       = RULE_NONE;
        bad_d        = 1'b0;
      end
    end
  end

  assign push_o  = accept && (rec_line || rec_sum);
  assign entry_o = {rec_line, rec_sum, sum_bad, cnt_inc, sum_after, line_stop, line_begin_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_seen_q <= '0;
      line_begin_q <= '0;
      after_nl_q   <= '0;
      line_hit_q   <= 1'b0;
      fill_q       <= '0;
      pend_q       <= 2'd0;
      rule_q       <= RULE_NONE;
      bad_q        <= 1'b0;
    end else begin
      bytes_seen_q <= bytes_seen_d;
      line_begin_q <= line_begin_d;
      after_nl_q   <= after_nl_d;
      line_hit_q   <= line_hit_d;
      fill_q       <= fill_d;
      pend_q       <= pend_d;
      rule_q       <= rule_d;
      bad_q        <= bad_d;
    end
  end

  // History of the current line, newest byte at index 0; the fill count
  // tells how much of it is valid.
  always_ff @(posedge clk_i) begin
    if (accept && !is_nl) begin
      hist_q[0] <= c;
      for (int i = 1; i < HistDepth; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

endmodule

/* hdl/tnlf_queue.sv */
module tnlf_queue #(
  parameter int Width = 8,
  parameter int Depth = tnlf_pkg::QueueDepth
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [Width-1:0]      data_i,
  output logic                  full_o,
  input  tnlf_pkg::queue_ctrl_t ctrl_i,
  output tnlf_pkg::queue_ctrl_t ctrl_o,
  output logic [Width-1:0]      data_o
);
  import tnlf_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_pop;

  assign full_o         = (count_q == CntW'(Depth));
  assign do_pop         = ctrl_i.pop && (count_q != '0);
  assign ctrl_o.not_empty = (count_q != '0);
  assign ctrl_o.pop     = do_pop;
  assign data_o         = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (int'(wr_ptr_q) == Depth - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (int'(rd_ptr_q) == Depth - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (!push_i && do_pop) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* hdl/tnlf_back.sv */
module tnlf_back #(
  parameter int OffsetBits = tnlf_pkg::OffsetBitsDef,
  localparam int EntryW    = 4 * OffsetBits + 3,
  localparam int OutW      = ((4 * OffsetBits + 1 + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [OffsetBits-1:0] base_offset_i,
  input  tnlf_pkg::queue_ctrl_t ctrl_i,
  output tnlf_pkg::queue_ctrl_t ctrl_o,
  input  logic [EntryW-1:0]     entry_i,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OutW-1:0]       m_axis_tdata,
  output logic                  m_axis_tuser,
  output logic                  m_axis_tlast
);
  import tnlf_pkg::*;

  localparam int PadW = OutW - (4 * OffsetBits + 1);

  logic [OffsetBits-1:0] e_begin, e_end, e_after, e_total;
  logic                  e_bad, e_sum, e_line;

  assign {e_line, e_sum, e_bad, e_total, e_after, e_end, e_begin} = entry_i;

  function automatic logic [OffsetBits-1:0] sat_add(logic [OffsetBits-1:0] a,
                                                    logic [OffsetBits-1:0] b);
    logic [OffsetBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[OffsetBits] ? '1 : s[OffsetBits-1:0];
  endfunction

  logic [OffsetBits-1:0] line_ofs, line_len, cpl_ofs, tot_size;

  assign line_ofs = sat_add(base_offset_i, e_begin);
  assign line_len = e_end - e_begin;
  assign cpl_ofs  = sat_add(base_offset_i, e_after);
  assign tot_size = sat_add(base_offset_i, e_total);

  logic            valid_q, valid_d;
  logic            phase_q, phase_d;
  logic [OutW-1:0] data_q, data_d;
  logic            kind_q, kind_d;
  logic            last_q, last_d;
  logic            load, pop;

  assign load = ctrl_i.not_empty && (!valid_q || m_axis_tready);

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    data_d  = data_q;
    kind_d  = kind_q;
    last_d  = last_q;
    pop     = 1'b0;
    if (valid_q && m_axis_tready) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      if (e_line && !phase_q) begin
        data_d = {PadW'(0), 1'b0, {OffsetBits{1'b0}}, {OffsetBits{1'b0}}, line_len, line_ofs};
        kind_d = KIND_LINE;
        last_d = !e_sum;
        pop    = !e_sum;
        phase_d = e_sum;
      end else begin
        data_d  = {PadW'(0), e_bad, tot_size, cpl_ofs, {OffsetBits{1'b0}},
                   {OffsetBits{1'b0}}};
        kind_d  = KIND_SUMMARY;
        last_d  = 1'b1;
        pop     = 1'b1;
        phase_d = 1'b0;
      end
    end
  end

  assign ctrl_o.pop       = pop;
  assign ctrl_o.not_empty = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    kind_q <= kind_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = data_q;
  assign m_axis_tuser  = kind_q;
  assign m_axis_tlast  = last_q;

endmodule

/* hdl/two_needle_line_filter_top.sv */
// A byte's records pass through the record queue and then the output register before
// m_axis_tvalid rises. Throughput: one byte per cycle while the record queue is not full;
// the front compares both needle windows each byte.
// A last byte whose line is also reported yields one entry of the four-entry record queue,
// which the back emits as two beats (line, then summary); m_axis_tready sets the drain rate.
// Reset (rst_ni low, asynchronous) clears the stream state, the queue, the output valid flag
// and all configuration registers to zero; the empty queue then holds s_axis_tready high.
module two_needle_line_filter_top #(
  parameter int NeedleBytes = tnlf_pkg::NeedleBytesDef,
  parameter int OffsetBits  = tnlf_pkg::OffsetBitsDef,
  localparam int OutW       = ((4 * OffsetBits + 1 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write port: register index i is the i-th register of the map.
  input  logic                          cfg_we_i,
  input  logic [tnlf_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [tnlf_pkg::CfgDataW-1:0] cfg_data_i,
  // Input stream, one text byte per beat.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata,   // byte_value
  input  logic                          s_axis_tlast,   // is_last
  // Output stream, one record per beat.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // line_offset, line_length, tail_offset, total_size, tail_invalid, zero pad
  output logic [OutW-1:0]               m_axis_tdata,
  output logic                          m_axis_tuser,   // record_kind
  output logic                          m_axis_tlast    // final_record
);
  import tnlf_pkg::*;

  localparam int EntryW = 4 * OffsetBits + 3;

  // Configuration registers. They are to be written by the user only while the block is idle
  // (the block does not enforce it), so the front and back read them directly.
  logic                  scan_all_q;
  logic [OffsetBits-1:0] base_offset_q;
  logic [LenW-1:0]       first_len_q, second_len_q;
  logic [PatW-1:0]       first_lo_q, first_hi_q, second_lo_q, second_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_all_q    <= 1'b0;
      base_offset_q <= '0;
      first_len_q   <= '0;
      second_len_q  <= '0;
      first_lo_q    <= '0;
      first_hi_q    <= '0;
      second_lo_q   <= '0;
      second_hi_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_SCAN_ALL:      scan_all_q    <= cfg_data_i[0];
        CFG_BASE_OFFSET:   base_offset_q <= cfg_data_i[OffsetBits-1:0];
        CFG_FIRST_LEN:     first_len_q   <= cfg_data_i[LenW-1:0];
        CFG_SECOND_LEN:    second_len_q  <= cfg_data_i[LenW-1:0];
        CFG_FIRST_PAT_LO:  first_lo_q    <= cfg_data_i[PatW-1:0];
        CFG_FIRST_PAT_HI:  first_hi_q    <= cfg_data_i[PatW-1:0];
        CFG_SECOND_PAT_LO: second_lo_q   <= cfg_data_i[PatW-1:0];
        CFG_SECOND_PAT_HI: second_hi_q   <= cfg_data_i[PatW-1:0];
        default: begin
        end
      endcase
    end
  end

  needle_cfg_t needle_cfg;

  assign needle_cfg.scan_all   = scan_all_q;
  assign needle_cfg.first_len  = first_len_q;
  assign needle_cfg.second_len = second_len_q;
  assign needle_cfg.first_pat  = {first_hi_q, first_lo_q};
  assign needle_cfg.second_pat = {second_hi_q, second_lo_q};

  // Front: splits lines, tracks needle hits and UTF-8 state, and queues one
  // record entry per byte that causes results.
  logic              push, full;
  logic [EntryW-1:0] wr_entry, rd_entry;
  queue_ctrl_t       q_to_back, back_to_q;

  tnlf_front #(
    .NeedleBytes (NeedleBytes),
    .OffsetBits  (OffsetBits)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (needle_cfg),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .entry_o       (wr_entry)
  );

  // Short queue so the input side keeps moving while the output stalls.
  tnlf_queue #(
    .Width (EntryW),
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (wr_entry),
    .full_o (full),
    .ctrl_i (back_to_q),
    .ctrl_o (q_to_back),
    .data_o (rd_entry)
  );

  // Back: turns relative counts into absolute offsets and emits one or two
  // beats per entry through the output register.
  tnlf_back #(
    .OffsetBits (OffsetBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .base_offset_i (base_offset_q),
    .ctrl_i        (q_to_back),
    .ctrl_o        (back_to_q),
    .entry_i       (rd_entry),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
